// ===== rtl/core/ccirc_pkg.sv =====
// Shared widths and status codes for the circumcircle pipeline.
package ccirc_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DET_W      = PROD_W + 1;
    localparam int SQ_W       = 2 * COORD_BITS + 1;
    localparam int LO_W       = DIFF_W;
    localparam int HI_W       = SQ_W - LO_W;
    localparam int PL_W       = LO_W + 1 + DIFF_W;
    localparam int PH_W       = HI_W + 1 + DIFF_W;
    localparam int NUM_W      = SQ_W + DIFF_W + 1;
    localparam int DIVN_W     = NUM_W + 1;
    localparam int DIVD_W     = DET_W + 1;
    localparam int Q_BITS     = 34;
    localparam int DV_W       = DIVD_W + Q_BITS;
    localparam int OUT_W      = 32;
    localparam int CW         = Q_BITS + 2;
    localparam int SUM_W      = 2 * OUT_W + 1;
    localparam int ROOT_W     = OUT_W + 1;
    localparam int SREM_W     = SUM_W + 1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_COLLINEAR = 2'd1,
        ST_SAT       = 2'd2
    } t_status;

endpackage

// ===== rtl/core/ccirc_pt_if.sv =====
// Point-triple input channel.
interface ccirc_pt_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [ccirc_pkg::COORD_BITS-1:0]  ax;
    logic signed [ccirc_pkg::COORD_BITS-1:0]  ay;
    logic signed [ccirc_pkg::COORD_BITS-1:0]  bx;
    logic signed [ccirc_pkg::COORD_BITS-1:0]  by;
    logic signed [ccirc_pkg::COORD_BITS-1:0]  cx;
    logic signed [ccirc_pkg::COORD_BITS-1:0]  cy;

    modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
    modport sink   (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

// ===== rtl/core/ccirc_res_if.sv =====
// Circle result channel.
interface ccirc_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [ccirc_pkg::OUT_W-1:0]  center_x;
    logic signed [ccirc_pkg::OUT_W-1:0]  center_y;
    logic        [ccirc_pkg::OUT_W-1:0]  radius;
    ccirc_pkg::t_status                  status;

    modport source (output valid, center_x, center_y, radius, status, input ready);
    modport sink   (input valid, center_x, center_y, radius, status, output ready);
endinterface

// ===== rtl/core/circumcircle_from_three_points_top.sv =====
// Circumcircle of three points: deep pipeline, one beat per cycle unless stalled.
//
//  channel | dir | beat contents
//  --------+-----+-------------------------------------------------
//  i_pts   | in  | ax, ay, bx, by, cx, cy  (Q11.12, 24 bit signed)
//  o_res   | out | center_x, center_y (s32), radius (u32), status
//
// Throughput is one beat per cycle unless the output stalls; the pipeline
// holds a bit-per-stage quotient (34 stages) and square root (33 stages).
// i_rst_n is synchronous; it clears only the stage valid bits.
// The whole pipeline advances when the output register is empty or taken,
// so a stall freezes every stage in place and nothing is lost or repeated.
module circumcircle_from_three_points_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ccirc_pt_if.sink         i_pts,
    ccirc_res_if.source      o_res
);

    // One quotient-pipeline stage: x and y share the divisor.
    typedef struct packed {
        logic [ccirc_pkg::DIVN_W-1:0]             rem_x;
        logic [ccirc_pkg::DIVN_W-1:0]             rem_y;
        logic [ccirc_pkg::Q_BITS-1:0]             q_x;
        logic [ccirc_pkg::Q_BITS-1:0]             q_y;
        logic [ccirc_pkg::DIVD_W-1:0]             d2;
        logic                                     neg_x;
        logic                                     neg_y;
        logic                                     ovf_x;
        logic                                     ovf_y;
        logic                                     col;
        logic signed [ccirc_pkg::COORD_BITS-1:0]  ax;
        logic signed [ccirc_pkg::COORD_BITS-1:0]  ay;
    } t_div;

    // Finished center, carried alongside the radius work.
    typedef struct packed {
        logic [ccirc_pkg::OUT_W-1:0]  cen_x;
        logic [ccirc_pkg::OUT_W-1:0]  cen_y;
        logic                         sat;
        logic                         big;
        logic                         col;
    } t_cn;

    // One square-root stage.
    typedef struct packed {
        logic [ccirc_pkg::SUM_W-1:0]   rem;
        logic [ccirc_pkg::ROOT_W-1:0]  root;
        t_cn                           cn;
    } t_sq;

    localparam logic [ccirc_pkg::OUT_W-1:0] S_MAX = {1'b0, {(ccirc_pkg::OUT_W-1){1'b1}}};
    localparam logic [ccirc_pkg::OUT_W-1:0] S_MIN = {1'b1, {(ccirc_pkg::OUT_W-1){1'b0}}};

    // {saturated, value}
    function automatic logic [ccirc_pkg::OUT_W:0] f_clamp(
        input logic signed [ccirc_pkg::CW-1:0] v,
        input logic ovf,
        input logic neg
    );
        if (ovf) begin
            return {1'b1, (neg ? S_MIN : S_MAX)};
        end
        if ((&v[ccirc_pkg::CW-1:ccirc_pkg::OUT_W-1]) ||
            (~|v[ccirc_pkg::CW-1:ccirc_pkg::OUT_W-1])) begin
            return {1'b0, v[ccirc_pkg::OUT_W-1:0]};
        end
        return {1'b1, (v[ccirc_pkg::CW-1] ? S_MIN : S_MAX)};
    endfunction

    logic adv;
    logic r_out_valid;

    assign adv         = !r_out_valid || o_res.ready;
    assign i_pts.ready = adv;

    // ---- stage 1: differences relative to the first point
    logic r1_v;
    logic signed [ccirc_pkg::COORD_BITS-1:0] r1_ax, r1_ay;
    logic signed [ccirc_pkg::DIFF_W-1:0]     r1_dbx, r1_dby, r1_dcx, r1_dcy;

    // ---- stage 2: 25x25 products
    logic r2_v;
    logic signed [ccirc_pkg::COORD_BITS-1:0] r2_ax, r2_ay;
    logic signed [ccirc_pkg::DIFF_W-1:0]     r2_dbx, r2_dby, r2_dcx, r2_dcy;
    logic signed [ccirc_pkg::PROD_W-1:0]     r2_pbc, r2_pcb, r2_bxx, r2_byy, r2_cxx, r2_cyy;

    // ---- stage 3: determinant and squared lengths
    logic r3_v;
    logic signed [ccirc_pkg::COORD_BITS-1:0] r3_ax, r3_ay;
    logic signed [ccirc_pkg::DIFF_W-1:0]     r3_dbx, r3_dby, r3_dcx, r3_dcy;
    logic signed [ccirc_pkg::DET_W-1:0]      r3_d;
    logic        [ccirc_pkg::SQ_W-1:0]       r3_sb, r3_sc;

    // ---- stage 4: split partial products of the numerators
    logic r4_v;
    logic signed [ccirc_pkg::COORD_BITS-1:0] r4_ax, r4_ay;
    logic signed [ccirc_pkg::DET_W-1:0]      r4_d;
    logic signed [ccirc_pkg::PL_W-1:0]       r4_xl0, r4_xl1, r4_yl0, r4_yl1;
    logic signed [ccirc_pkg::PH_W-1:0]       r4_xh0, r4_xh1, r4_yh0, r4_yh1;

    // ---- stage 5: numerators
    logic r5_v;
    logic signed [ccirc_pkg::COORD_BITS-1:0] r5_ax, r5_ay;
    logic signed [ccirc_pkg::DET_W-1:0]      r5_d;
    logic signed [ccirc_pkg::NUM_W-1:0]      r5_nx, r5_ny;

    // ---- stage 6: magnitudes for rounded division
    logic r6_v;
    logic signed [ccirc_pkg::COORD_BITS-1:0] r6_ax, r6_ay;
    logic        [ccirc_pkg::DIVN_W-1:0]     r6_nx, r6_ny;
    logic        [ccirc_pkg::DIVD_W-1:0]     r6_d2;
    logic                                    r6_negx, r6_negy, r6_col;

    logic signed [ccirc_pkg::LO_W:0]    w_sbl, w_scl;
    logic signed [ccirc_pkg::HI_W:0]    w_sbh, w_sch;
    logic        [ccirc_pkg::NUM_W-1:0] w_nax, w_nay;
    logic        [ccirc_pkg::DET_W-1:0] w_dab;

    always_comb begin
        w_sbl = $signed({1'b0, r3_sb[ccirc_pkg::LO_W-1:0]});
        w_sbh = $signed({1'b0, r3_sb[ccirc_pkg::SQ_W-1:ccirc_pkg::LO_W]});
        w_scl = $signed({1'b0, r3_sc[ccirc_pkg::LO_W-1:0]});
        w_sch = $signed({1'b0, r3_sc[ccirc_pkg::SQ_W-1:ccirc_pkg::LO_W]});
        w_nax = r5_nx[ccirc_pkg::NUM_W-1] ? ccirc_pkg::NUM_W'(-r5_nx) : ccirc_pkg::NUM_W'(r5_nx);
        w_nay = r5_ny[ccirc_pkg::NUM_W-1] ? ccirc_pkg::NUM_W'(-r5_ny) : ccirc_pkg::NUM_W'(r5_ny);
        w_dab = r5_d[ccirc_pkg::DET_W-1]  ? ccirc_pkg::DET_W'(-r5_d)  : ccirc_pkg::DET_W'(r5_d);
    end

    // quotient pipeline, entry 0 holds the overflow check
    t_div r_dv   [0:ccirc_pkg::Q_BITS];
    logic r_dv_v [0:ccirc_pkg::Q_BITS];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_ax  <= i_pts.ax;
            r1_ay  <= i_pts.ay;
            r1_dbx <= ccirc_pkg::DIFF_W'(i_pts.bx) - ccirc_pkg::DIFF_W'(i_pts.ax);
            r1_dby <= ccirc_pkg::DIFF_W'(i_pts.by) - ccirc_pkg::DIFF_W'(i_pts.ay);
            r1_dcx <= ccirc_pkg::DIFF_W'(i_pts.cx) - ccirc_pkg::DIFF_W'(i_pts.ax);
            r1_dcy <= ccirc_pkg::DIFF_W'(i_pts.cy) - ccirc_pkg::DIFF_W'(i_pts.ay);

            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_dbx <= r1_dbx;
            r2_dby <= r1_dby;
            r2_dcx <= r1_dcx;
            r2_dcy <= r1_dcy;
            r2_pbc <= r1_dbx * r1_dcy;
            r2_pcb <= r1_dcx * r1_dby;
            r2_bxx <= r1_dbx * r1_dbx;
            r2_byy <= r1_dby * r1_dby;
            r2_cxx <= r1_dcx * r1_dcx;
            r2_cyy <= r1_dcy * r1_dcy;

            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_dbx <= r2_dbx;
            r3_dby <= r2_dby;
            r3_dcx <= r2_dcx;
            r3_dcy <= r2_dcy;
            r3_d   <= ccirc_pkg::DET_W'(r2_pbc) - ccirc_pkg::DET_W'(r2_pcb);
            r3_sb  <= ccirc_pkg::SQ_W'(r2_bxx[ccirc_pkg::SQ_W-2:0])
                    + ccirc_pkg::SQ_W'(r2_byy[ccirc_pkg::SQ_W-2:0]);
            r3_sc  <= ccirc_pkg::SQ_W'(r2_cxx[ccirc_pkg::SQ_W-2:0])
                    + ccirc_pkg::SQ_W'(r2_cyy[ccirc_pkg::SQ_W-2:0]);

            // nx = sb*dcy - sc*dby ; ny = dbx*sc - dcx*sb
            r4_ax  <= r3_ax;
            r4_ay  <= r3_ay;
            r4_d   <= r3_d;
            r4_xl0 <= w_sbl * r3_dcy;
            r4_xh0 <= w_sbh * r3_dcy;
            r4_xl1 <= w_scl * r3_dby;
            r4_xh1 <= w_sch * r3_dby;
            r4_yl0 <= w_scl * r3_dbx;
            r4_yh0 <= w_sch * r3_dbx;
            r4_yl1 <= w_sbl * r3_dcx;
            r4_yh1 <= w_sbh * r3_dcx;

            r5_ax <= r4_ax;
            r5_ay <= r4_ay;
            r5_d  <= r4_d;
            r5_nx <= ((ccirc_pkg::NUM_W'(r4_xh0) <<< ccirc_pkg::LO_W) + ccirc_pkg::NUM_W'(r4_xl0))
                   - ((ccirc_pkg::NUM_W'(r4_xh1) <<< ccirc_pkg::LO_W) + ccirc_pkg::NUM_W'(r4_xl1));
            r5_ny <= ((ccirc_pkg::NUM_W'(r4_yh0) <<< ccirc_pkg::LO_W) + ccirc_pkg::NUM_W'(r4_yl0))
                   - ((ccirc_pkg::NUM_W'(r4_yh1) <<< ccirc_pkg::LO_W) + ccirc_pkg::NUM_W'(r4_yl1));

            // round to nearest: floor((|n| + |d|) / (2|d|))
            r6_ax   <= r5_ax;
            r6_ay   <= r5_ay;
            r6_nx   <= ccirc_pkg::DIVN_W'(w_nax) + ccirc_pkg::DIVN_W'(w_dab);
            r6_ny   <= ccirc_pkg::DIVN_W'(w_nay) + ccirc_pkg::DIVN_W'(w_dab);
            r6_d2   <= {w_dab, 1'b0};
            r6_negx <= r5_nx[ccirc_pkg::NUM_W-1] ^ r5_d[ccirc_pkg::DET_W-1];
            r6_negy <= r5_ny[ccirc_pkg::NUM_W-1] ^ r5_d[ccirc_pkg::DET_W-1];
            r6_col  <= (r5_d == '0);

            r_dv[0].rem_x <= r6_nx;
            r_dv[0].rem_y <= r6_ny;
            r_dv[0].q_x   <= '0;
            r_dv[0].q_y   <= '0;
            r_dv[0].d2    <= r6_d2;
            r_dv[0].neg_x <= r6_negx;
            r_dv[0].neg_y <= r6_negy;
            r_dv[0].ovf_x <= ccirc_pkg::DV_W'(r6_nx) >= (ccirc_pkg::DV_W'(r6_d2) << ccirc_pkg::Q_BITS);
            r_dv[0].ovf_y <= ccirc_pkg::DV_W'(r6_ny) >= (ccirc_pkg::DV_W'(r6_d2) << ccirc_pkg::Q_BITS);
            r_dv[0].col   <= r6_col;
            r_dv[0].ax    <= r6_ax;
            r_dv[0].ay    <= r6_ay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v      <= 1'b0;
            r2_v      <= 1'b0;
            r3_v      <= 1'b0;
            r4_v      <= 1'b0;
            r5_v      <= 1'b0;
            r6_v      <= 1'b0;
            r_dv_v[0] <= 1'b0;
        end else if (adv) begin
            r1_v      <= i_pts.valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r4_v      <= r3_v;
            r5_v      <= r4_v;
            r6_v      <= r5_v;
            r_dv_v[0] <= r6_v;
        end
    end

    // one quotient bit per stage, MSB first
    for (genvar k = 0; k < ccirc_pkg::Q_BITS; k++) begin : g_div
        localparam int SH = ccirc_pkg::Q_BITS - 1 - k;
        logic [ccirc_pkg::DV_W-1:0] w_tx, w_ty, w_rx, w_ry;
        t_div w_n;

        always_comb begin
            w_tx = ccirc_pkg::DV_W'(r_dv[k].d2) << SH;
            w_ty = w_tx;
            w_rx = ccirc_pkg::DV_W'(r_dv[k].rem_x);
            w_ry = ccirc_pkg::DV_W'(r_dv[k].rem_y);
            w_n  = r_dv[k];
            if (w_rx >= w_tx) begin
                w_n.rem_x = ccirc_pkg::DIVN_W'(w_rx - w_tx);
                w_n.q_x   = {r_dv[k].q_x[ccirc_pkg::Q_BITS-2:0], 1'b1};
            end else begin
                w_n.q_x   = {r_dv[k].q_x[ccirc_pkg::Q_BITS-2:0], 1'b0};
            end
            if (w_ry >= w_ty) begin
                w_n.rem_y = ccirc_pkg::DIVN_W'(w_ry - w_ty);
                w_n.q_y   = {r_dv[k].q_y[ccirc_pkg::Q_BITS-2:0], 1'b1};
            end else begin
                w_n.q_y   = {r_dv[k].q_y[ccirc_pkg::Q_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv[k+1] <= w_n;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end
    end

    // ---- center: add back the first point and clamp
    t_div w_dq;
    logic signed [ccirc_pkg::CW-1:0]   w_qsx, w_qsy, w_sumx, w_sumy;
    logic        [ccirc_pkg::OUT_W:0]  w_clx, w_cly;

    always_comb begin
        w_dq   = r_dv[ccirc_pkg::Q_BITS];
        w_qsx  = $signed(ccirc_pkg::CW'(w_dq.q_x));
        w_qsy  = $signed(ccirc_pkg::CW'(w_dq.q_y));
        if (w_dq.neg_x) begin
            w_qsx = -w_qsx;
        end
        if (w_dq.neg_y) begin
            w_qsy = -w_qsy;
        end
        w_sumx = ccirc_pkg::CW'(w_dq.ax) + w_qsx;
        w_sumy = ccirc_pkg::CW'(w_dq.ay) + w_qsy;
        w_clx  = f_clamp(w_sumx, w_dq.ovf_x, w_dq.neg_x);
        w_cly  = f_clamp(w_sumy, w_dq.ovf_y, w_dq.neg_y);
    end

    logic                          r_c_v, r_m_v;
    t_cn                           r_c_cn, r_m_cn;
    logic [ccirc_pkg::OUT_W-1:0]   r_c_mx, r_c_my;
    logic [2*ccirc_pkg::OUT_W-1:0] r_m_sx, r_m_sy;

    t_sq  r_sq   [0:ccirc_pkg::ROOT_W];
    logic r_sq_v [0:ccirc_pkg::ROOT_W];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_cn.cen_x <= w_clx[ccirc_pkg::OUT_W-1:0];
            r_c_cn.cen_y <= w_cly[ccirc_pkg::OUT_W-1:0];
            r_c_cn.sat   <= w_clx[ccirc_pkg::OUT_W] | w_cly[ccirc_pkg::OUT_W];
            // radius needs both offsets inside 32 bits
            r_c_cn.big   <= w_dq.ovf_x | w_dq.ovf_y
                          | (|w_dq.q_x[ccirc_pkg::Q_BITS-1:ccirc_pkg::OUT_W])
                          | (|w_dq.q_y[ccirc_pkg::Q_BITS-1:ccirc_pkg::OUT_W]);
            r_c_cn.col   <= w_dq.col;
            r_c_mx       <= w_dq.q_x[ccirc_pkg::OUT_W-1:0];
            r_c_my       <= w_dq.q_y[ccirc_pkg::OUT_W-1:0];

            r_m_cn <= r_c_cn;
            r_m_sx <= r_c_mx * r_c_mx;
            r_m_sy <= r_c_my * r_c_my;

            r_sq[0].rem  <= ccirc_pkg::SUM_W'(r_m_sx) + ccirc_pkg::SUM_W'(r_m_sy);
            r_sq[0].root <= '0;
            r_sq[0].cn   <= r_m_cn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v     <= 1'b0;
            r_m_v     <= 1'b0;
            r_sq_v[0] <= 1'b0;
        end else if (adv) begin
            r_c_v     <= r_dv_v[ccirc_pkg::Q_BITS];
            r_m_v     <= r_c_v;
            r_sq_v[0] <= r_m_v;
        end
    end

    // digit-by-digit square root: rem holds s - root^2
    for (genvar k = 0; k < ccirc_pkg::ROOT_W; k++) begin : g_sqrt
        localparam int B = ccirc_pkg::ROOT_W - 1 - k;
        logic [ccirc_pkg::SREM_W-1:0] w_term, w_rem;
        t_sq w_n;

        always_comb begin
            w_term = (ccirc_pkg::SREM_W'(r_sq[k].root) << (B + 1))
                   + (ccirc_pkg::SREM_W'(1) << (2 * B));
            w_rem  = ccirc_pkg::SREM_W'(r_sq[k].rem);
            w_n    = r_sq[k];
            if (w_rem >= w_term) begin
                w_n.rem     = ccirc_pkg::SUM_W'(w_rem - w_term);
                w_n.root[B] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq[k+1] <= w_n;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end
    end

    // ---- output register: round the root, clamp, pick status
    t_sq                            w_fin;
    logic [ccirc_pkg::ROOT_W:0]     w_rr;
    logic                           w_rsat;

    always_comb begin
        w_fin  = r_sq[ccirc_pkg::ROOT_W];
        w_rr   = ccirc_pkg::ROOT_W'(w_fin.root) + (ccirc_pkg::ROOT_W+1)'(
                     w_fin.rem > ccirc_pkg::SUM_W'(w_fin.root));
        w_rsat = w_fin.cn.big | (|w_rr[ccirc_pkg::ROOT_W:ccirc_pkg::OUT_W]);
    end

    logic signed [ccirc_pkg::OUT_W-1:0] r_cen_x, r_cen_y;
    logic        [ccirc_pkg::OUT_W-1:0] r_rad;
    ccirc_pkg::t_status                 r_status;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (w_fin.cn.col) begin
                r_cen_x  <= '0;
                r_cen_y  <= '0;
                r_rad    <= '0;
                r_status <= ccirc_pkg::ST_COLLINEAR;
            end else begin
                r_cen_x  <= w_fin.cn.cen_x;
                r_cen_y  <= w_fin.cn.cen_y;
                r_rad    <= w_rsat ? '1 : w_rr[ccirc_pkg::OUT_W-1:0];
                r_status <= (w_rsat | w_fin.cn.sat) ? ccirc_pkg::ST_SAT : ccirc_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_sq_v[ccirc_pkg::ROOT_W];
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.center_x = r_cen_x;
    assign o_res.center_y = r_cen_y;
    assign o_res.radius   = r_rad;
    assign o_res.status   = r_status;

endmodule

// ===== bench/circumcircle_from_three_points_top_tb.sv =====
// Testbench for the circumcircle pipeline: directed table plus random triples.
`timescale 1ns / 1ps

module circumcircle_from_three_points_top_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1250;

    typedef logic signed [ccirc_pkg::COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [31:0]        rad;
        ccirc_pkg::t_status st;
    } t_circle;

    // one directed row; has_exp marks rows whose result is typed in here
    typedef struct {
        t_coord  p[6];
        bit      has_exp;
        t_circle exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    int   cycles;
    int   errors;
    int   n_checked;
    int   n_collinear;
    int   n_saturated;

    t_circle circle_q[$];

    ccirc_pt_if  pts_if ();
    ccirc_res_if res_if ();

    circumcircle_from_three_points_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pts   (pts_if.sink),
        .o_res   (res_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("circumcircle_from_three_points_top: mismatch");
            $finish;
        end
    end

    // |v| as 64 bits, v assumed to fit
    function automatic logic [63:0] mag64(logic signed [127:0] v);
        logic signed [127:0] a;
        a = v < 0 ? -v : v;
        return a[63:0];
    endfunction

    // round(num / (2 den)) with ties away from zero
    function automatic logic signed [127:0] half_quot(logic signed [127:0] num,
                                                       logic signed [127:0] den);
        logic [127:0] n, d, q;
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        q = (n + d) / (d << 1);
        return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [31:0] clamp_s32(logic signed [127:0] v, inout bit sat);
        if (v > 128'sh7FFFFFFF) begin
            sat = 1;
            return 32'h7FFFFFFF;
        end
        if (v < -128'sh80000000) begin
            sat = 1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // distance from the center offset to the first point, rounded to nearest
    function automatic logic [31:0] dist_round(logic signed [127:0] ox,
                                               logic signed [127:0] oy, inout bit sat);
        logic [127:0] s, c, r;
        if (mag64(ox) > 64'hFFFFFFFF || mag64(oy) > 64'hFFFFFFFF ||
            (ox < 0 ? -ox : ox) > 128'hFFFFFFFF || (oy < 0 ? -oy : oy) > 128'hFFFFFFFF) begin
            sat = 1;
            return 32'hFFFFFFFF;
        end
        s = ox * ox + oy * oy;
        r = 0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= s) r = c;
        end
        if (s > r * r + r) r = r + 1;
        if (r > 128'hFFFFFFFF) begin
            sat = 1;
            return 32'hFFFFFFFF;
        end
        return r[31:0];
    endfunction

    function automatic t_circle predict_circle(t_coord p[6]);
        logic signed [127:0] ax, ay, bx, by, cx, cy, d, sb, sc, nx, ny, qx, qy;
        t_circle r;
        bit sat;
        sat = 0;
        ax = p[0]; ay = p[1];
        bx = p[2] - ax; by = p[3] - ay;
        cx = p[4] - ax; cy = p[5] - ay;
        d = bx * cy - cx * by;
        if (d == 0) begin
            r.cx = 0; r.cy = 0; r.rad = 0; r.st = ccirc_pkg::ST_COLLINEAR;
            return r;
        end
        sb = bx * bx + by * by;
        sc = cx * cx + cy * cy;
        nx = sb * cy - sc * by;
        ny = bx * sc - cx * sb;
        qx = half_quot(nx, d);
        qy = half_quot(ny, d);
        r.cx  = clamp_s32(ax + qx, sat);
        r.cy  = clamp_s32(ay + qy, sat);
        r.rad = dist_round(qx, qy, sat);
        r.st  = sat ? ccirc_pkg::ST_SAT : ccirc_pkg::ST_OK;
        return r;
    endfunction

    // valid drops only across an idle gap; the caller drops it after the last beat
    task automatic send_triple(t_coord p[6], bit has_exp, t_circle exp);
        t_circle want;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            pts_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        want = predict_circle(p);
        if (has_exp && want != exp)
            $display("%0t table row disagrees with prediction", $time);
        pts_if.valid <= 1'b1;
        pts_if.ax <= p[0]; pts_if.ay <= p[1];
        pts_if.bx <= p[2]; pts_if.by <= p[3];
        pts_if.cx <= p[4]; pts_if.cy <= p[5];
        @(posedge i_clk);
        while (!pts_if.ready) @(posedge i_clk);
        circle_q.push_back(has_exp ? exp : want);
        @(negedge i_clk);
    endtask

    // checker: every accepted result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_circle e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (circle_q.size() == 0) begin
                errors++;
                $display("%0t result beat with nothing expected: %0d %0d %0d %0d", $time,
                         res_if.center_x, res_if.center_y, res_if.radius, res_if.status);
            end else begin
                e = circle_q.pop_front();
                n_checked++;
                if (e.st == ccirc_pkg::ST_COLLINEAR) n_collinear++;
                if (e.st == ccirc_pkg::ST_SAT) n_saturated++;
                if (res_if.center_x !== e.cx || res_if.center_y !== e.cy ||
                    res_if.radius !== e.rad || res_if.status !== e.st) begin
                    errors++;
                    $display("%0t expected cx=%0d cy=%0d r=%0d st=%0d got cx=%0d cy=%0d r=%0d st=%0d",
                             $time, e.cx, e.cy, e.rad, e.st, res_if.center_x,
                             res_if.center_y, res_if.radius, res_if.status);
                end
            end
        end
    end

    // receiver: random stalls per beat, with calm stretches
    initial begin
        int stall;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            @(negedge i_clk);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!(res_if.valid && res_if.ready)) @(posedge i_clk);
        end
    end

    function automatic t_coord rnd_coord();
        case ($urandom_range(0, 5))
            0: return t_coord'($urandom);
            1: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
            2: return t_coord'($signed($urandom_range(0, 8191)) - 4096);
            default: return t_coord'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    initial begin
        t_row    dir[$];
        t_row    row;
        t_coord  p[6];
        t_circle none;
        t_coord  k;
        none = '{0, 0, 0, ccirc_pkg::ST_OK};
        errors = 0; cycles = 0; n_checked = 0; n_collinear = 0; n_saturated = 0;
        i_rst_n = 1'b0;
        pts_if.valid = 1'b0;
        {pts_if.ax, pts_if.ay, pts_if.bx, pts_if.by, pts_if.cx, pts_if.cy} = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all zero: repeated point, collinear
        dir.push_back('{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, ccirc_pkg::ST_COLLINEAR}});
        // points on one line
        dir.push_back('{'{0, 0, 4096, 4096, 8192, 8192}, 1,
                        '{0, 0, 0, ccirc_pkg::ST_COLLINEAR}});
        // unit right triangle at origin: center (0.5, 0.5)
        dir.push_back('{'{0, 0, 4096, 0, 0, 4096}, 0, none});
        // symmetric triangle: center at origin, radius 1.0
        dir.push_back('{'{4096, 0, -4096, 0, 0, 4096}, 1, '{0, 0, 4096, ccirc_pkg::ST_OK}});
        // extremes of the field
        dir.push_back('{'{24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000, -24'sh800000,
                          24'sh7FFFFF, -24'sh800000}, 0, none});
        dir.push_back('{'{-24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                          -24'sh800000, -24'sh800000}, 0, none});
        dir.push_back('{'{-24'sh800000, -24'sh800000, -24'sh800000, -24'sh800000,
                          24'sh7FFFFF, 24'sh7FFFFF}, 1, '{0, 0, 0, ccirc_pkg::ST_COLLINEAR}});
        // nearly collinear: huge center, saturates
        dir.push_back('{'{0, 0, 24'sh7FFFFF, 0, -24'sh800000, 1}, 0, none});
        dir.push_back('{'{0, 0, 24'sh7FFFFF, 1, -24'sh800000, 0}, 0, none});
        dir.push_back('{'{-24'sh800000, 0, 24'sh7FFFFF, 0, 0, -1}, 0, none});
        // tiny triangles, rounding ties
        dir.push_back('{'{0, 0, 1, 0, 0, 1}, 0, none});
        dir.push_back('{'{0, 0, 1, 0, 0, -1}, 0, none});
        dir.push_back('{'{0, 0, -1, 0, 0, -1}, 0, none});
        dir.push_back('{'{5, -3, 6, -3, 5, -2}, 0, none});
        dir.push_back('{'{0, 0, 3, 1, 1, 2}, 0, none});
        foreach (dir[i]) begin
            row = dir[i];
            send_triple(row.p, row.has_exp, row.exp);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            foreach (p[j]) p[j] = rnd_coord();
            case ($urandom_range(0, 9))
                0: begin   // repeat a point
                    p[2] = p[0]; p[3] = p[1];
                end
                1: begin   // third point on line through first two
                    k = t_coord'($urandom_range(0, 3));
                    p[4] = p[0] + k * (p[2] - p[0]);
                    p[5] = p[1] + k * (p[3] - p[1]);
                end
                2: begin   // near-collinear skinny triangle
                    p[4] = -p[2]; p[5] = -p[3] + t_coord'($urandom_range(0, 2));
                    p[0] = 0; p[1] = 0;
                end
                default: ;
            endcase
            send_triple(p, 0, none);
        end
        pts_if.valid <= 1'b0;

        while (circle_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("checked %0d circles (%0d collinear, %0d saturated)",
                 n_checked, n_collinear, n_saturated);
        $display("directed rows %0d, random triples %0d", dir.size(), N_RANDOM);
        if (errors == 0)
            $display("circumcircle_from_three_points_top: match");
        else
            $display("circumcircle_from_three_points_top: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/ccirc_pkg.sv
rtl/core/ccirc_pt_if.sv
rtl/core/ccirc_res_if.sv
rtl/core/circumcircle_from_three_points_top.sv
bench/circumcircle_from_three_points_top_tb.sv
